>>> rtl/afls_pkg.sv
package afls_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned LEVEL_W     = 16;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned DC_THR_W    = 15;
  localparam int unsigned SUM_EVERY_W = 8;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam int unsigned CFG_IDX_W   = 1;

  // Stream widths
  localparam int unsigned S_TDATA_W = 2 * SAMPLE_W;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 3 * COUNT_W + 4 * LEVEL_W;

  // Divider: quotient is a level, always below 2**QUO_W
  localparam int unsigned QUO_W  = LEVEL_W;
  localparam int unsigned STEP_W = $clog2(QUO_W);

  localparam int unsigned MAX_FRAME_SAMPLES_DEF = 1024;

  localparam logic [DC_THR_W-1:0]    DC_THR_RST    = 15'd2000;
  localparam logic [SUM_EVERY_W-1:0] SUM_EVERY_RST = 8'd25;
  localparam logic [LEVEL_W-1:0]     NO_LEVEL      = '1;
  localparam logic [COUNT_W-1:0]     COUNT_MAX     = '1;

  typedef enum logic [S_TUSER_W-1:0] {
    ACT_SAMPLE,
    ACT_FAILED,
    ACT_EMPTY
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DC_THRESHOLD,
    CFG_SUMMARY_EVERY
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_LEFT,
    DIV_RIGHT,
    DIV_DC
  } div_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_SAVE,
    ST_FRAME_END,
    ST_CHECK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic    sample;
    logic    failed_inc;
    logic    event_inc;
    logic    div_load;
    logic    div_step;
    logic    div_save;
    logic    frame_end;
    logic    emit;
    div_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic interval_hit;
  } dp_status_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

>>> rtl/afls_div.sv
// Restoring divider, one quotient bit per step. Quotient must fit QUO_W bits.
module afls_div #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned SUM_W = 26
) (
  input  logic                        clk_i,
  input  logic                        load_i,
  input  logic                        step_i,
  input  logic [SUM_W-1:0]            dividend_i,
  input  logic [CNT_W-1:0]            divisor_i,
  output logic [afls_pkg::QUO_W-1:0]  quotient_o
);

  localparam int unsigned QW    = afls_pkg::QUO_W;
  localparam int unsigned REM_W = CNT_W + 1;
  localparam int unsigned ACC_W = REM_W + QW;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [REM_W-1:0] rem_sh, dsr, diff;
  logic             fits;

  always_comb begin
    rem_sh = {acc_q[ACC_W-2:QW], acc_q[QW-1]};
    dsr    = REM_W'(divisor_i);
    fits   = rem_sh >= dsr;
    diff   = rem_sh - dsr;
    acc_d  = acc_q;
    if (load_i) begin
      acc_d = ACC_W'(dividend_i);
    end else if (step_i) begin
      acc_d = {(fits ? diff : rem_sh), acc_q[QW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign quotient_o = acc_q[QW-1:0];

endmodule

>>> rtl/afls_ctrl.sv
module afls_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_tvalid_i,
  input  logic                   s_tlast_i,
  input  logic [afls_pkg::S_TUSER_W-1:0] action_i,
  output logic                   s_tready_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  input  afls_pkg::dp_status_t   status_i,
  output afls_pkg::ctrl_cmd_t    cmd_o
);

  afls_pkg::state_e              state_q, state_d;
  afls_pkg::div_op_e             op_q, op_d;
  logic [afls_pkg::STEP_W-1:0]   step_q, step_d;
  logic                          out_valid_q, out_valid_d;
  logic                          emit_ok;
  afls_pkg::action_e             action;

  assign action  = afls_pkg::action_e'(action_i);
  assign emit_ok = !out_valid_q || m_tready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    step_d  = step_q;
    case (state_q)
      afls_pkg::ST_IDLE: begin
        if (s_tvalid_i) begin
          case (action)
            afls_pkg::ACT_SAMPLE: begin
              if (s_tlast_i) begin
                state_d = afls_pkg::ST_DIV_LOAD;
                op_d    = afls_pkg::DIV_LEFT;
              end
            end
            afls_pkg::ACT_FAILED: state_d = afls_pkg::ST_CHECK;
            afls_pkg::ACT_EMPTY:  state_d = afls_pkg::ST_CHECK;
            default:              state_d = afls_pkg::ST_IDLE;
          endcase
        end
      end
      afls_pkg::ST_DIV_LOAD: begin
        state_d = afls_pkg::ST_DIV_STEP;
        step_d  = '0;
      end
      afls_pkg::ST_DIV_STEP: begin
        step_d = step_q + 1'b1;
        if (step_q == afls_pkg::STEP_W'(afls_pkg::QUO_W - 1)) begin
          state_d = afls_pkg::ST_DIV_SAVE;
        end
      end
      afls_pkg::ST_DIV_SAVE: begin
        case (op_q)
          afls_pkg::DIV_LEFT: begin
            op_d    = afls_pkg::DIV_RIGHT;
            state_d = afls_pkg::ST_DIV_LOAD;
          end
          afls_pkg::DIV_RIGHT: begin
            op_d    = afls_pkg::DIV_DC;
            state_d = afls_pkg::ST_DIV_LOAD;
          end
          default: state_d = afls_pkg::ST_FRAME_END;
        endcase
      end
      afls_pkg::ST_FRAME_END: state_d = afls_pkg::ST_CHECK;
      afls_pkg::ST_CHECK: begin
        state_d = status_i.interval_hit ? afls_pkg::ST_EMIT : afls_pkg::ST_IDLE;
      end
      afls_pkg::ST_EMIT: begin
        if (emit_ok) state_d = afls_pkg::ST_IDLE;
      end
      default: state_d = afls_pkg::ST_IDLE;
    endcase

    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = op_q;
    s_tready_o = 1'b0;
    case (state_q)
      afls_pkg::ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          case (action)
            afls_pkg::ACT_SAMPLE: cmd_o.sample = 1'b1;
            afls_pkg::ACT_FAILED: begin
              cmd_o.failed_inc = 1'b1;
              cmd_o.event_inc  = 1'b1;
            end
            afls_pkg::ACT_EMPTY: cmd_o.event_inc = 1'b1;
            default: ;
          endcase
        end
      end
      afls_pkg::ST_DIV_LOAD:  cmd_o.div_load  = 1'b1;
      afls_pkg::ST_DIV_STEP:  cmd_o.div_step  = 1'b1;
      afls_pkg::ST_DIV_SAVE:  cmd_o.div_save  = 1'b1;
      afls_pkg::ST_FRAME_END: cmd_o.frame_end = 1'b1;
      afls_pkg::ST_EMIT:      cmd_o.emit      = emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= afls_pkg::ST_IDLE;
      op_q        <= afls_pkg::DIV_LEFT;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign m_tvalid_o = out_valid_q;

endmodule

>>> rtl/afls_dp.sv
module afls_dp #(
  parameter int unsigned MAX_FRAME_SAMPLES = afls_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [afls_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [afls_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic [afls_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  afls_pkg::ctrl_cmd_t               cmd_i,
  output afls_pkg::dp_status_t              status_o,
  output logic [afls_pkg::M_TDATA_W-1:0]    m_tdata_o
);

  localparam int unsigned SW     = afls_pkg::SAMPLE_W;
  localparam int unsigned LW     = afls_pkg::LEVEL_W;
  localparam int unsigned CW     = afls_pkg::COUNT_W;
  localparam int unsigned CNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned SUM_W  = $clog2(MAX_FRAME_SAMPLES * (2 ** (SW - 1)) + 1);
  localparam int unsigned SSUM_W = SUM_W + 1;

  // Configuration
  logic [afls_pkg::DC_THR_W-1:0]    dc_thr_q;
  logic [afls_pkg::SUM_EVERY_W-1:0] sum_every_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_thr_q    <= afls_pkg::DC_THR_RST;
      sum_every_q <= afls_pkg::SUM_EVERY_RST;
    end else if (cfg_we_i) begin
      case (afls_pkg::cfg_idx_e'(cfg_idx_i))
        afls_pkg::CFG_DC_THRESHOLD:  dc_thr_q    <= cfg_wdata_i[afls_pkg::DC_THR_W-1:0];
        afls_pkg::CFG_SUMMARY_EVERY: sum_every_q <= cfg_wdata_i[afls_pkg::SUM_EVERY_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame and interval state
  logic [CNT_W-1:0]         n_q, n_d;
  logic [SUM_W-1:0]         labs_q, labs_d, rabs_q, rabs_d;
  logic signed [SSUM_W-1:0] lsum_q, lsum_d;
  logic                     lzero_q, lzero_d;
  logic [CW-1:0]            interval_q, interval_d, failed_q, failed_d;
  logic [CW-1:0]            silent_q, silent_d, dc_q, dc_d;
  logic [LW-1:0]            lmin_q, lmin_d, lmax_q, lmax_d;
  logic [LW-1:0]            rmin_q, rmin_d, rmax_q, rmax_d;

  // Frame-end quotients
  logic [LW-1:0] lvl_l_q, lvl_r_q, mean_abs_q;

  logic signed [SW-1:0] l_smp, r_smp;
  logic [SW-1:0]        l_abs, r_abs;
  logic                 room;
  logic [SSUM_W-1:0]    lsum_neg;
  logic [SUM_W-1:0]     lsum_abs, dividend;
  logic [LW-1:0]        quotient;

  assign l_smp    = s_tdata_i[SW-1:0];
  assign r_smp    = s_tdata_i[2*SW-1:SW];
  assign l_abs    = l_smp[SW-1] ? (~l_smp + 1'b1) : l_smp;
  assign r_abs    = r_smp[SW-1] ? (~r_smp + 1'b1) : r_smp;
  assign room     = n_q < CNT_W'(MAX_FRAME_SAMPLES);
  assign lsum_neg = ~lsum_q + 1'b1;
  assign lsum_abs = lsum_q[SSUM_W-1] ? lsum_neg[SUM_W-1:0] : lsum_q[SUM_W-1:0];

  always_comb begin
    case (cmd_i.op)
      afls_pkg::DIV_LEFT:  dividend = labs_q;
      afls_pkg::DIV_RIGHT: dividend = rabs_q;
      default:             dividend = lsum_abs;
    endcase
  end

  afls_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_save) begin
      case (cmd_i.op)
        afls_pkg::DIV_LEFT:  lvl_l_q    <= quotient;
        afls_pkg::DIV_RIGHT: lvl_r_q    <= quotient;
        default:             mean_abs_q <= quotient;
      endcase
    end
  end

  always_comb begin
    n_d        = n_q;
    labs_d     = labs_q;
    rabs_d     = rabs_q;
    lsum_d     = lsum_q;
    lzero_d    = lzero_q;
    interval_d = interval_q;
    failed_d   = failed_q;
    silent_d   = silent_q;
    dc_d       = dc_q;
    lmin_d     = lmin_q;
    lmax_d     = lmax_q;
    rmin_d     = rmin_q;
    rmax_d     = rmax_q;

    if (cmd_i.sample && room) begin
      labs_d = labs_q + SUM_W'(l_abs);
      rabs_d = rabs_q + SUM_W'(r_abs);
      lsum_d = lsum_q + SSUM_W'(l_smp);
      if (l_smp != '0) lzero_d = 1'b0;
      n_d = n_q + 1'b1;
    end
    if (cmd_i.failed_inc) failed_d = afls_pkg::sat_inc(failed_q);
    if (cmd_i.event_inc)  interval_d = afls_pkg::sat_inc(interval_q);

    if (cmd_i.frame_end) begin
      if (n_q != '0) begin
        if (lvl_l_q < lmin_q) lmin_d = lvl_l_q;
        if (lvl_l_q > lmax_q) lmax_d = lvl_l_q;
        if (lvl_r_q < rmin_q) rmin_d = lvl_r_q;
        if (lvl_r_q > rmax_q) rmax_d = lvl_r_q;
        if (lzero_q) silent_d = afls_pkg::sat_inc(silent_q);
        if (mean_abs_q > LW'(dc_thr_q)) dc_d = afls_pkg::sat_inc(dc_q);
      end
      n_d        = '0;
      labs_d     = '0;
      rabs_d     = '0;
      lsum_d     = '0;
      lzero_d    = 1'b1;
      interval_d = afls_pkg::sat_inc(interval_q);
    end

    if (cmd_i.emit) begin
      interval_d = '0;
      failed_d   = '0;
      silent_d   = '0;
      dc_d       = '0;
      lmin_d     = afls_pkg::NO_LEVEL;
      lmax_d     = '0;
      rmin_d     = afls_pkg::NO_LEVEL;
      rmax_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q        <= '0;
      labs_q     <= '0;
      rabs_q     <= '0;
      lsum_q     <= '0;
      lzero_q    <= 1'b1;
      interval_q <= '0;
      failed_q   <= '0;
      silent_q   <= '0;
      dc_q       <= '0;
      lmin_q     <= afls_pkg::NO_LEVEL;
      lmax_q     <= '0;
      rmin_q     <= afls_pkg::NO_LEVEL;
      rmax_q     <= '0;
    end else begin
      n_q        <= n_d;
      labs_q     <= labs_d;
      rabs_q     <= rabs_d;
      lsum_q     <= lsum_d;
      lzero_q    <= lzero_d;
      interval_q <= interval_d;
      failed_q   <= failed_d;
      silent_q   <= silent_d;
      dc_q       <= dc_d;
      lmin_q     <= lmin_d;
      lmax_q     <= lmax_d;
      rmin_q     <= rmin_d;
      rmax_q     <= rmax_d;
    end
  end

  assign status_o.interval_hit = interval_q >= sum_every_q;

  // Output beat register; a missing minimum reads as zero
  logic [afls_pkg::M_TDATA_W-1:0] m_tdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      m_tdata_q <= {rmax_q,
                    (rmin_q == afls_pkg::NO_LEVEL) ? LW'(0) : rmin_q,
                    lmax_q,
                    (lmin_q == afls_pkg::NO_LEVEL) ? LW'(0) : lmin_q,
                    dc_q, silent_q, failed_q};
    end
  end

  assign m_tdata_o = m_tdata_q;

endmodule

>>> rtl/audio_frame_level_stats.sv
// Audio frame level statistics. Stereo sample pairs arrive on the slave stream
// (tuser = action: sample pair, failed read or empty read; tlast closes a frame).
// At each frame end the truncated mean absolute level of both channels and the
// truncated left mean magnitude are found with one shared restoring divider, one
// quotient bit per cycle, three divisions in turn. Per interval the block keeps
// level min/max, silent-frame, DC-biased-frame and failed-read counts; after
// summary_every events (frames, failed reads, empty reads) it sends one summary
// beat and clears the interval. A sample pair that does not close a frame leaves
// the block ready for the next beat; a failed or empty read goes through the
// summary check (and the summary emit when it triggers one); a frame-closing
// pair goes through three divisions (load, quotient steps, save), the frame
// update and the summary check. The summary sits in an output register, so
// input keeps flowing while it waits; only a second summary stalls behind an
// untaken one. Pairs past MAX_FRAME_SAMPLES in one frame are dropped, but their
// tlast still ends the frame. Action code 3 is ignored.
module audio_frame_level_stats #(
  parameter int unsigned MAX_FRAME_SAMPLES = afls_pkg::MAX_FRAME_SAMPLES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [afls_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [afls_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Slave stream
  input  logic                              s_tvalid_i,
  output logic                              s_tready_o,
  input  logic [afls_pkg::S_TDATA_W-1:0]    s_tdata_i,   // left_sample, right_sample
  input  logic [afls_pkg::S_TUSER_W-1:0]    s_tuser_i,   // action
  input  logic                              s_tlast_i,   // frame_last
  // Master stream
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  // failed_reads, silent_frames, dc_bias_frames, left_level_min,
  // left_level_max, right_level_min, right_level_max
  output logic [afls_pkg::M_TDATA_W-1:0]    m_tdata_o
);

  afls_pkg::ctrl_cmd_t  cmd;
  afls_pkg::dp_status_t status;

  afls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tlast_i  (s_tlast_i),
    .action_i   (s_tuser_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  afls_dp #(
    .MAX_FRAME_SAMPLES (MAX_FRAME_SAMPLES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_tdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tdata_o   (m_tdata_o)
  );

  // Output field offsets for the checks below
  localparam int unsigned LMIN_LO = 3 * afls_pkg::COUNT_W;
  localparam int unsigned LMAX_LO = LMIN_LO + afls_pkg::LEVEL_W;
  localparam int unsigned RMIN_LO = LMAX_LO + afls_pkg::LEVEL_W;
  localparam int unsigned RMAX_LO = RMIN_LO + afls_pkg::LEVEL_W;
  localparam int unsigned LW      = afls_pkg::LEVEL_W;

  logic frame_close_acc, read_event_acc;

  assign frame_close_acc = s_tvalid_i && s_tready_o && s_tlast_i &&
                           (s_tuser_i == afls_pkg::ACT_SAMPLE);
  assign read_event_acc  = s_tvalid_i && s_tready_o &&
                           ((s_tuser_i == afls_pkg::ACT_FAILED) ||
                            (s_tuser_i == afls_pkg::ACT_EMPTY));

  // Frame close starts the divider sequence, no new beat taken meanwhile
  a_frame_close_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_close_acc |=> !s_tready_o)
    else $error("beat accepted right after frame close");

  // A read event always goes through the summary check
  a_read_event_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_event_acc |=> !s_tready_o)
    else $error("beat accepted right after read event");

  // Summary levels are ordered and in range
  a_left_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[LMIN_LO +: LW] <= m_tdata_o[LMAX_LO +: LW]) &&
                   (m_tdata_o[LMAX_LO +: LW] <= 16'd32768))
    else $error("left level min/max inconsistent");

  a_right_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[RMIN_LO +: LW] <= m_tdata_o[RMAX_LO +: LW]) &&
                   (m_tdata_o[RMAX_LO +: LW] <= 16'd32768))
    else $error("right level min/max inconsistent");

endmodule
